// ----- hw/rtl/pmp_pkg.sv -----
// Shared types and constants for the physical memory protection unit.
// Depends on nothing; imported only by the top level.
package pmp_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WSEL,
		ST_RD_NXT,
		ST_RD_PREV,
		ST_RD_CUR,
		ST_MOD,
		ST_ONES,
		ST_WR,
		ST_WR_NXT,
		ST_ADV,
		ST_RRD,
		ST_RCAP,
		ST_SCAN,
		ST_DONE
	} state_t;

	localparam logic [2:0] OP_CFG_WR  = 3'd0;
	localparam logic [2:0] OP_CFG_RD  = 3'd1;
	localparam logic [2:0] OP_ADDR_WR = 3'd2;
	localparam logic [2:0] OP_ADDR_RD = 3'd3;
	localparam logic [2:0] OP_CHECK   = 3'd4;
	localparam logic [2:0] OP_SEARCH  = 3'd5;

	localparam logic [1:0] MODE_OFF   = 2'd0;
	localparam logic [1:0] MODE_TOR   = 2'd1;
	localparam logic [1:0] MODE_NA4   = 2'd2;
	localparam logic [1:0] MODE_NAPOT = 2'd3;

	localparam int        LOCK_BIT = 7;
	localparam logic [2:0] RWX     = 3'b111;

	// entry number built from a 4-bit cfg register index and byte lane
	localparam int ENT_W  = 6;
	// scan pointer must reach the entry count itself (up to 64)
	localparam int SCAN_W = 7;
	localparam int G_W    = 6;

endpackage

// ----- hw/rtl/pmp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the PMP entry words.
module pmp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic [AW-1:0]        raddr,
	output logic [WIDTH-1:0]     rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/physical_memory_protection_unit.sv -----
// Top level of the RISC-V physical memory protection unit.
// Depends on pmp_pkg and pmp_ram (entry word storage).
//
// Usage: a command is accepted when start is high and busy is low; its
// operand ports are sampled at that edge. One result comes back on
// read_value, permissions, match_found and match_index, valid for the single
// cycle in which done is high; fields not produced by the command are zero.
// One command is in flight at a time; busy stays high until after done.
// All commands go through one entry RAM read port and one range decoder under
// the sequencer. A cfg write handles the four entries of its register in turn,
// an addr write one entry; both skip a locked entry, count the trailing ones
// of the address for NAPOT, and an addr write also rewrites the range of a TOR
// successor. Check and overlap search scan entries until one decides or all
// are scanned; a check with no active rules finishes without a scan. A cfg
// write passes over entries past the last one.
// The APB port holds the priv_spec_1_11 register (paddr is not decoded); write it
// only while busy is low. Reset clears all entries (per-entry valid flags),
// the grain pin and the active rule count, and sets priv_spec_1_11.
// The result cannot be held off; the receiver takes it in the done cycle.
module physical_memory_protection_unit
	import pmp_pkg::*;
#(
	parameter int NUM_ENTRIES = 16,
	parameter int XLEN        = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  operation,
	input  logic [3:0]  entry_index,
	input  logic [31:0] write_value,
	input  logic [31:0] access_addr,
	input  logic [31:0] access_size,
	input  logic        machine_mode,
	output logic        done,
	output logic [31:0] read_value,
	output logic [2:0]  permissions,
	output logic        match_found,
	output logic [3:0]  match_index,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int IW    = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int CNT_W = $clog2(NUM_ENTRIES + 1);
	localparam int WW    = 40 + 2 * XLEN;
	localparam int A_LO  = 2 * XLEN;
	localparam int C_LO  = 2 * XLEN + 32;
	localparam logic [SCAN_W-1:0] N_LIM = SCAN_W'(NUM_ENTRIES);

	state_t state_q, state_d;

	logic [2:0]         op_q;
	logic [31:0]        wval_q, addr_q, last_q;
	logic               mach_q;
	logic [ENT_W-1:0]   ent_q;
	logic [1:0]         k_q;
	logic [7:0]         nxt_cfg_q;
	logic [31:0]        nxt_addr_q;
	logic               nxt_ok_q;
	logic [31:0]        prev_addr_q;
	logic [7:0]         cfg_q;
	logic [31:0]        caddr_q;
	logic               old_on_q;
	logic [31:0]        sh_q;
	logic [G_W-1:0]     g_q;
	logic [SCAN_W-1:0]  scan_q, pidx_q;
	logic               pend_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [G_W-1:0]     pin_q;
	logic               pin_flag_q;
	logic               priv_q;
	logic [NUM_ENTRIES-1:0] valid_q;
	logic               rd_ok_q;
	logic [31:0]        rv_q;
	logic [2:0]         perm_q;
	logic               found_q;
	logic [3:0]         midx_q;

	logic               ram_we;
	logic [IW-1:0]      ram_waddr, ram_raddr;
	logic [WW-1:0]      ram_wdata, ram_rdata, w;
	logic [7:0]         w_cfg;
	logic [31:0]        w_addr;
	logic [XLEN-1:0]    w_start, w_end;

	logic [SCAN_W-1:0]  ent_x, raddr_x;
	logic               ent_in, nxt_in;
	logic [ENT_W-1:0]   ent_p1, ent_m1;
	logic [7:0]         wbyte;
	logic [1:0]         new_mode;
	logic               locked;

	// range decoder
	logic [1:0]         dmode;
	logic [31:0]        dcur, dprev;
	logic [G_W-1:0]     dg, g_eff;
	logic [XLEN-1:0]    cur_x, prev_x, nmask, base, sa, ea;
	logic [XLEN+3:0]    sp_w;
	logic [6:0]         sh1, sh3;

	// scan evaluation
	logic [XLEN-1:0]    ax, lx;
	logic               s_in, e_in, chk_decide, srch_hit, decided;
	logic [2:0]         chk_perm;
	logic               rd_ok_d;

	assign w       = rd_ok_q ? ram_rdata : '0;
	assign w_end   = w[XLEN-1:0];
	assign w_start = w[A_LO-1:XLEN];
	assign w_addr  = w[C_LO-1:A_LO];
	assign w_cfg   = w[WW-1:C_LO];

	assign ent_x  = {1'b0, ent_q};
	assign ent_in = ent_x < N_LIM;
	assign nxt_in = (ent_x + SCAN_W'(1)) < N_LIM;
	assign ent_p1 = ent_q + ENT_W'(1);
	assign ent_m1 = ent_q - ENT_W'(1);
	assign wbyte  = wval_q[{k_q, 3'b000} +: 8];

	assign new_mode = (op_q == OP_CFG_WR) ? wbyte[4:3] : w_cfg[4:3];
	assign locked   = w_cfg[LOCK_BIT] |
	                  (nxt_ok_q & nxt_cfg_q[LOCK_BIT] & (nxt_cfg_q[4:3] == MODE_TOR));

	// grain sharing under priv 1.11
	assign g_eff = (priv_q && cfg_q[4:3] == MODE_NAPOT && pin_flag_q) ? pin_q : g_q;

	always_comb begin
		if (state_q == ST_WR_NXT) begin
			dmode = MODE_TOR;
			dcur  = nxt_addr_q;
			dprev = caddr_q;
			dg    = g_q;
		end else begin
			dmode = cfg_q[4:3];
			dcur  = caddr_q;
			dprev = prev_addr_q;
			dg    = g_eff;
		end
	end

	assign cur_x  = XLEN'(dcur);
	assign prev_x = XLEN'(dprev);
	assign sh1    = {1'b0, dg} + 7'd1;
	assign sh3    = {1'b0, dg} + 7'd3;
	assign nmask  = {XLEN{1'b1}} << sh1;
	assign base   = (cur_x & nmask) << 2;
	assign sp_w   = ((XLEN + 4)'(1) << sh3) - (XLEN + 4)'(1);

	always_comb begin
		sa = '0;
		ea = '1;
		case (dmode)
			MODE_TOR: begin
				sa = prev_x << 2;
				ea = (cur_x << 2) - XLEN'(1);
			end
			MODE_NA4: begin
				sa = cur_x << 2;
				ea = (cur_x << 2) + XLEN'(3);
			end
			MODE_NAPOT: begin
				if ((dcur == 32'hFFFF_FFFF && XLEN == 32) || dg >= G_W'(61)) begin
					sa = '0;
					ea = '1;
				end else begin
					sa = base;
					ea = base + sp_w[XLEN-1:0];
				end
			end
			default: begin
				sa = '0;
				ea = '1;
			end
		endcase
	end

	// scan compare
	assign ax         = XLEN'(addr_q);
	assign lx         = XLEN'(last_q);
	assign s_in       = (ax >= w_start) && (ax <= w_end);
	assign e_in       = (lx >= w_start) && (lx <= w_end);
	assign chk_decide = (s_in != e_in) || (s_in && e_in && w_cfg[4:3] != MODE_OFF);
	assign chk_perm   = (s_in != e_in) ? 3'b000 :
	                    ((!mach_q || w_cfg[LOCK_BIT]) ? w_cfg[2:0] : RWX);
	assign srch_hit   = (w_start < ax) ? (w_end >= ax) : (w_start <= lx);
	assign decided    = (op_q == OP_CHECK) ? chk_decide : srch_hit;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (operation)
						OP_CFG_WR, OP_ADDR_WR: state_d = ST_WSEL;
						OP_CFG_RD, OP_ADDR_RD: state_d = ST_RRD;
						OP_CHECK:  state_d = (cnt_q == '0) ? ST_DONE : ST_SCAN;
						OP_SEARCH: state_d = ST_SCAN;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_WSEL:    state_d = ent_in ? ST_RD_NXT : ST_ADV;
			ST_RD_NXT:  state_d = ST_RD_PREV;
			ST_RD_PREV: state_d = ST_RD_CUR;
			ST_RD_CUR:  state_d = ST_MOD;
			ST_MOD: begin
				if (locked) begin
					state_d = ST_ADV;
				end else if (new_mode == MODE_NAPOT) begin
					state_d = ST_ONES;
				end else begin
					state_d = ST_WR;
				end
			end
			ST_ONES:    state_d = sh_q[0] ? ST_ONES : ST_WR;
			ST_WR: begin
				if (op_q == OP_ADDR_WR && nxt_ok_q && nxt_cfg_q[4:3] == MODE_TOR) begin
					state_d = ST_WR_NXT;
				end else begin
					state_d = ST_ADV;
				end
			end
			ST_WR_NXT:  state_d = ST_ADV;
			ST_ADV:     state_d = (op_q == OP_CFG_WR && k_q != 2'd3) ? ST_WSEL : ST_DONE;
			ST_RRD:     state_d = ST_RCAP;
			ST_RCAP:    state_d = (k_q == 2'd3) ? ST_DONE : ST_RRD;
			ST_SCAN: begin
				if (pend_q && decided) begin
					state_d = ST_DONE;
				end else if (!pend_q && scan_q >= N_LIM) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE:    state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// RAM port and status outputs
	always_comb begin
		raddr_x = ent_x;
		case (state_q)
			ST_RD_NXT:  raddr_x = {1'b0, ent_p1};
			ST_RD_PREV: raddr_x = {1'b0, ent_m1};
			ST_SCAN:    raddr_x = scan_q;
			default:    raddr_x = ent_x;
		endcase
		ram_raddr = raddr_x[IW-1:0];
		ram_we    = (state_q == ST_WR) || (state_q == ST_WR_NXT);
		ram_waddr = (state_q == ST_WR_NXT) ? ent_p1[IW-1:0] : ent_q[IW-1:0];
		if (state_q == ST_WR_NXT) begin
			ram_wdata = {nxt_cfg_q, nxt_addr_q, sa, ea};
		end else begin
			ram_wdata = {cfg_q, caddr_q, sa, ea};
		end
		busy = (state_q != ST_IDLE);
		done = (state_q == ST_DONE);
	end

	assign rd_ok_d = (raddr_x < N_LIM) ? valid_q[ram_raddr] : 1'b0;

	pmp_ram #(
		.WIDTH (WW),
		.DEPTH (NUM_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			pin_q      <= '0;
			pin_flag_q <= 1'b0;
			priv_q     <= 1'b1;
			valid_q    <= '0;
			pend_q     <= 1'b0;
			rd_ok_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_ok_q <= rd_ok_d;
			if (psel && penable && pwrite && pready) begin
				priv_q <= pwdata[0];
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (state_q == ST_WR) begin
				if (priv_q && cfg_q[4:3] == MODE_NAPOT && !pin_flag_q) begin
					pin_q      <= g_q;
					pin_flag_q <= 1'b1;
				end
				if (op_q == OP_CFG_WR) begin
					if (cfg_q[4:3] != MODE_OFF && !old_on_q) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end else if (cfg_q[4:3] == MODE_OFF && old_on_q) begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
			end
			if (state_q == ST_SCAN) begin
				if (pend_q && decided) begin
					pend_q <= 1'b0;
				end else begin
					pend_q <= (scan_q < N_LIM);
				end
			end else begin
				pend_q <= 1'b0;
			end
		end
	end

	// operands, captured words and results
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					op_q   <= operation;
					wval_q <= write_value;
					addr_q <= access_addr;
					last_q <= access_addr + access_size - 32'd1;
					mach_q <= machine_mode;
					rv_q    <= '0;
					perm_q  <= '0;
					found_q <= 1'b0;
					midx_q  <= '0;
					scan_q  <= '0;
					k_q     <= 2'd0;
					ent_q   <= {entry_index, 2'b00};
					case (operation)
						OP_ADDR_WR, OP_ADDR_RD: begin
							ent_q <= {2'b00, entry_index};
							k_q   <= 2'd3;
						end
						OP_CHECK: begin
							perm_q <= (cnt_q == '0 || machine_mode) ? RWX : 3'b000;
						end
						OP_SEARCH: begin
							scan_q <= {3'b000, entry_index};
						end
						default: begin
							k_q <= 2'd0;
						end
					endcase
				end
			end
			ST_RD_PREV: begin
				nxt_ok_q   <= nxt_in;
				nxt_cfg_q  <= nxt_in ? w_cfg : 8'd0;
				nxt_addr_q <= nxt_in ? w_addr : 32'd0;
			end
			ST_RD_CUR: begin
				prev_addr_q <= (ent_q != '0) ? w_addr : 32'd0;
			end
			ST_MOD: begin
				old_on_q <= (w_cfg[4:3] != MODE_OFF);
				cfg_q    <= (op_q == OP_CFG_WR) ? wbyte : w_cfg;
				caddr_q  <= (op_q == OP_ADDR_WR) ? wval_q : w_addr;
				sh_q     <= (op_q == OP_ADDR_WR) ? wval_q : w_addr;
				g_q      <= '0;
			end
			ST_ONES: begin
				// count trailing ones of the address, one bit a cycle
				if (sh_q[0]) begin
					sh_q <= sh_q >> 1;
					g_q  <= g_q + G_W'(1);
				end
			end
			ST_ADV: begin
				k_q   <= k_q + 2'd1;
				ent_q <= ent_p1;
			end
			ST_RCAP: begin
				if (ent_in) begin
					if (op_q == OP_CFG_RD) begin
						rv_q[{k_q, 3'b000} +: 8] <= w_cfg;
					end else begin
						rv_q <= w_addr;
					end
				end
				k_q   <= k_q + 2'd1;
				ent_q <= ent_p1;
			end
			ST_SCAN: begin
				if (pend_q && decided) begin
					if (op_q == OP_CHECK) begin
						perm_q <= chk_perm;
					end else begin
						found_q <= 1'b1;
						midx_q  <= pidx_q[3:0];
					end
				end else if (scan_q < N_LIM) begin
					pidx_q <= scan_q;
					scan_q <= scan_q + SCAN_W'(1);
				end
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

	assign read_value  = rv_q;
	assign permissions = perm_q;
	assign match_found = found_q;
	assign match_index = midx_q;

	assign prdata = {31'd0, priv_q};
	assign pready = 1'b1;

endmodule

// ----- hw/rtl/pmp_chk.sv -----
// Port-level checker for the physical memory protection unit.
// Depends only on the top level's ports; bound to it below.
module pmp_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] read_value,
	input logic [2:0]  permissions,
	input logic        match_found,
	input logic [3:0]  match_index
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	a_done_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe outside a transaction");

	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("unit stayed busy after its result");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		done && read_value != 32'd0 |-> permissions == 3'd0 && !match_found)
		else $error("read data mixed with check or search result");

	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !match_found |-> match_index == 4'd0)
		else $error("match index set without a match");

endmodule

bind physical_memory_protection_unit pmp_chk u_pmp_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.read_value  (read_value),
	.permissions (permissions),
	.match_found (match_found),
	.match_index (match_index)
);
